### rtl/core/dtaq_pkg.sv
// ----------------------------------------------------------------------------
// dtaq_pkg
// Shared types and constants for the drop-tail acknowledgment queue.
// ----------------------------------------------------------------------------
package dtaq_pkg;

    // Sizing
    localparam int QUEUE_DEPTH = 64;
    localparam int NUM_PORTS   = 64;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = 7;
    localparam int ID_W        = 32;
    localparam int NODE_W      = 6;

    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(50);

    // Request kinds carried on s_tuser
    typedef enum logic [1:0] {
        ACT_FRAME = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_ACK   = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

    // One stored frame, new flag in the lowest bit
    typedef struct packed {
        logic [ID_W-1:0]   frame_id;
        logic [NODE_W-1:0] node;
        logic              is_new;
    } entry_t;

    // Input payload on s_tdata, last field in the lowest bits
    typedef struct packed {
        logic              pad;
        logic              is_new;
        logic [NODE_W-1:0] source_node;
        logic [ID_W-1:0]   frame_id;
    } in_data_t;

    // Result payload on m_tdata, last field in the lowest bits
    typedef struct packed {
        logic [CNT_W-1:0]  new_held_count;
        logic [CNT_W-1:0]  held_count;
        logic              ack_error;
        logic              frame_dropped;
        logic              ack_is_new;
        logic [NODE_W-1:0] ack_node;
        logic [ID_W-1:0]   ack_frame_id;
        logic              ack_valid;
    } out_data_t;

endpackage

### rtl/core/drop_tail_ack_queue.sv
// ----------------------------------------------------------------------------
// drop_tail_ack_queue
// Router frame queue with tail drop, acknowledging frames on each tick.
// ----------------------------------------------------------------------------
// Frames, ticks and stray acknowledgments arrive as requests on the slave
// stream and each yields exactly one result on the master stream. Frames are
// held in a 64-entry single-port-per-direction synchronous RAM. A frame
// arrival, a tick on an empty queue or any other request is answered in
// the idle state; a tick that pops a frame also passes through the read
// state, because the head entry has to come back from the registered RAM
// read before the new-frame counter can be updated. A new request is taken
// while the previous result waits, as long as it is being drained in the same cycle.
module drop_tail_ack_queue
    import dtaq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Configuration: queue_limit
    input  logic                    cfg_wr_en,
    input  logic [CNT_W-1:0]        cfg_wr_data,
    // Request stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [$bits(in_data_t)-1:0]  s_tdata,  // frame_id, source_node, is_new, pad
    input  logic [1:0]              s_tuser,  // action
    // Result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [$bits(out_data_t)-1:0] m_tdata  // ack_valid, ack_frame_id, ack_node,
                                                  // ack_is_new, frame_dropped, ack_error,
                                                  // held_count, new_held_count
);

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] head_ptr_reg, head_ptr_next;
    logic [PTR_W-1:0] tail_ptr_reg, tail_ptr_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic [CNT_W-1:0] new_held_reg, new_held_next;
    logic [CNT_W-1:0] limit_reg, limit_next;
    logic             m_tvalid_reg, m_tvalid_next;
    out_data_t        m_tdata_reg, m_tdata_next;

    entry_t           mem [QUEUE_DEPTH];
    entry_t           rd_data_reg;
    entry_t           wr_entry;
    logic             wr_en;
    logic             rd_en;

    in_data_t         in_d;
    action_t          in_act;
    logic             in_fire;
    logic             out_free;
    logic [CNT_W-1:0] limit_eff;
    logic             load_out;
    out_data_t        res;

    assign in_d     = in_data_t'(s_tdata);
    assign in_act   = action_t'(s_tuser);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Effective limit never exceeds the storage depth
    assign limit_eff = (limit_reg > CNT_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH) : limit_reg;

    assign wr_entry.frame_id = in_d.frame_id;
    assign wr_entry.node     = in_d.source_node;
    assign wr_entry.is_new   = in_d.is_new;

    // Frame store: write at tail, registered read at head
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_ptr_reg] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[head_ptr_reg];
        end
    end

    // Control and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_ptr_reg <= '0;
            tail_ptr_reg <= '0;
            held_reg     <= '0;
            new_held_reg <= '0;
            limit_reg    <= LIMIT_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_ptr_reg <= head_ptr_next;
            tail_ptr_reg <= tail_ptr_next;
            held_reg     <= held_next;
            new_held_reg <= new_held_next;
            limit_reg    <= limit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    // Sequencer: next state, counters, RAM strobes and result
    always_comb
    begin
        state_next    = state_reg;
        head_ptr_next = head_ptr_reg;
        tail_ptr_next = tail_ptr_reg;
        held_next     = held_reg;
        new_held_next = new_held_reg;
        limit_next    = cfg_wr_en ? cfg_wr_data : limit_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        load_out      = 1'b0;
        res           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_act)
                        ACT_FRAME:
                        begin
                            load_out = 1'b1;
                            if (held_reg >= limit_eff
                                || {1'b0, in_d.source_node} >= CNT_W'(NUM_PORTS))
                            begin
                                res.frame_dropped = 1'b1;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                tail_ptr_next = (tail_ptr_reg == PTR_W'(QUEUE_DEPTH - 1))
                                                ? '0 : tail_ptr_reg + PTR_W'(1);
                                held_next     = held_reg + CNT_W'(1);
                                new_held_next = new_held_reg + CNT_W'(in_d.is_new);
                            end
                        end
                        ACT_TICK:
                        begin
                            if (held_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_READ;
                            end
                            else
                            begin
                                load_out = 1'b1;
                            end
                        end
                        ACT_ACK:
                        begin
                            load_out      = 1'b1;
                            res.ack_error = 1'b1;
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // Head entry is back from the RAM: pop it
                load_out         = 1'b1;
                state_next       = ST_IDLE;
                head_ptr_next    = (head_ptr_reg == PTR_W'(QUEUE_DEPTH - 1))
                                   ? '0 : head_ptr_reg + PTR_W'(1);
                held_next        = held_reg - CNT_W'(1);
                if (rd_data_reg.is_new && new_held_reg != '0)
                begin
                    new_held_next = new_held_reg - CNT_W'(1);
                end
                res.ack_valid    = 1'b1;
                res.ack_frame_id = rd_data_reg.frame_id;
                res.ack_node     = rd_data_reg.node;
                res.ack_is_new   = rd_data_reg.is_new;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res.held_count     = held_next;
        res.new_held_count = new_held_next;

        // Output stage
        m_tdata_next = m_tdata_reg;
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = res;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

endmodule

### rtl/core/dtaq_checker.sv
// ----------------------------------------------------------------------------
// dtaq_props
// Port-level checks on the result stream of the drop-tail acknowledgment queue.
// ----------------------------------------------------------------------------
module dtaq_props
    import dtaq_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [$bits(out_data_t)-1:0] m_tdata
);

    out_data_t r;
    assign r = out_data_t'(m_tdata);

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One outcome at most per result
    a_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0({r.ack_valid, r.frame_dropped, r.ack_error}))
        else $error("more than one outcome flag set");

    // Acknowledgment fields are zero without an acknowledgment
    a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !r.ack_valid |->
            r.ack_frame_id == '0 && r.ack_node == '0 && !r.ack_is_new)
        else $error("acknowledgment fields set without acknowledgment");

    // Counters stay consistent
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> r.new_held_count <= r.held_count
                     && r.held_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue counters out of range");

endmodule

bind drop_tail_ack_queue dtaq_props u_dtaq_props (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
